// File: sv/ipwc_pkg.sv
// ----------------------------------------------------------------------------
// ipwc_pkg
// Shared types and constants for the IR pulse-width capture block.
// ----------------------------------------------------------------------------
`default_nettype none

package ipwc_pkg;

  // Default depth of the width store
  localparam int unsigned DEPTH_DEF = 128;

  // Field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned IDX_W   = 7;
  localparam int unsigned WIDTH_W = 8;
  localparam int unsigned CNT_W   = 8;

  // Reset value of the timeout limit register
  localparam logic [WIDTH_W-1:0] TIMEOUT_RESET = 8'hFF;

  // Item codes
  typedef enum logic [OP_W-1:0] {
    OP_EDGE    = 2'd0,
    OP_TICK    = 2'd1,
    OP_READ    = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  // Capture modes
  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_LOW   = 2'd1,
    MODE_HIGH  = 2'd2,
    MODE_DONE  = 2'd3
  } mode_t;

  // One result item
  typedef struct packed {
    mode_t              mode;
    logic               message_ready;
    logic [CNT_W-1:0]   pulse_count;
    logic [WIDTH_W-1:0] read_data;
  } result_t;

endpackage

`default_nettype wire

// File: sv/ipwc_store.sv
// ----------------------------------------------------------------------------
// ipwc_store
// Width store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ipwc_store #(
  parameter int unsigned DEPTH = ipwc_pkg::DEPTH_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [ipwc_pkg::WIDTH_W-1:0] wdata,
  input  wire logic                        re,
  input  wire logic [AW-1:0]               raddr,
  output logic      [ipwc_pkg::WIDTH_W-1:0] rdata
);
  import ipwc_pkg::*;

  logic [WIDTH_W-1:0] mem [DEPTH];

  // Write the captured width
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read an entry, hold the data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/ipwc_outq.sv
// ----------------------------------------------------------------------------
// ipwc_outq
// Three-entry result queue that decouples the output handshake from intake.
// ----------------------------------------------------------------------------
`default_nettype none

module ipwc_outq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire ipwc_pkg::result_t push_data,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output ipwc_pkg::result_t      out_data,
  output logic [1:0]             level
);
  import ipwc_pkg::*;

  localparam logic [1:0] LAST = 2'd2;

  result_t    slot [3];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic       pop;

  assign out_valid = (level != 2'd0);
  assign out_data  = slot[rd_ptr];
  assign pop       = out_valid && out_ready;

  // Store a pushed result
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      level  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? 2'd0 : wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? 2'd0 : rd_ptr + 2'd1;
      end
      case ({push, pop})
        2'b10:   level <= level + 2'd1;
        2'b01:   level <= level - 2'd1;
        default: level <= level;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/ir_pulse_width_capture.sv
// ----------------------------------------------------------------------------
// ir_pulse_width_capture
// Captures the low and high pulse widths of an IR message in timer ticks.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle: a pin edge, a timer tick, a read
// of a stored width or a release. Control state (mode, width count, tick
// counter, timer run flag) updates in the cycle of the transfer, and widths go
// to a single-port-write, registered-read store; a read therefore returns its
// data from the store in the following cycle. Each result passes through the
// read stage register and waits in a three-entry queue before it is offered on
// the output, so intake continues at full rate while the output side stalls
// briefly; in_ready drops only when the queue and the read stage together hold
// three results. The store needs no clearing after reset: its data is passed
// on only for entries below the current count.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pulse_width_capture #(
  parameter int unsigned DEPTH = ipwc_pkg::DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [ipwc_pkg::WIDTH_W-1:0] cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [ipwc_pkg::OP_W-1:0]    op,
  input  wire logic                         pin_level,
  input  wire logic [ipwc_pkg::IDX_W-1:0]   read_index,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [1:0]                        mode,
  output logic                              message_ready,
  output logic [ipwc_pkg::CNT_W-1:0]        pulse_count,
  output logic [ipwc_pkg::WIDTH_W-1:0]      read_data
);
  import ipwc_pkg::*;

  localparam int unsigned AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned XW  = ((CW > IDX_W) ? CW : IDX_W) + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [1:0] {
    EV_HIGH,
    EV_LOW,
    EV_TIMEOUT
  } ev_t;

  // Control state
  logic [WIDTH_W-1:0] timeout_limit;
  mode_t              mode_q;
  logic [CW-1:0]      count_q;
  logic [WIDTH_W-1:0] tick_q;
  logic               run_q;

  mode_t              mode_next;
  logic [CW-1:0]      count_next;
  logic [WIDTH_W-1:0] tick_next;
  logic               run_next;

  logic               in_xfer;
  op_t                op_c;
  logic               ev_go;
  ev_t                ev;
  logic               take_go;
  mode_t              take_mode;
  logic               we;
  logic               rd_ok;

  // Read stage
  logic               s1_valid;
  logic               s1_rd;
  mode_t              s1_mode;
  logic [CW-1:0]      s1_count;
  logic [WIDTH_W-1:0] rdata;
  result_t            s1_res;

  // Output queue
  result_t            q_data;
  logic [1:0]         q_level;
  logic [2:0]         occ;

  assign op_c    = op_t'(op);
  assign in_xfer = in_valid && in_ready;

  // Hold intake while queue plus read stage could not absorb another result
  assign occ      = {1'b0, q_level} + {2'b00, s1_valid};
  assign in_ready = (occ < 3'd3);

  // Read hits a written entry only below the count and the depth
  assign rd_ok = (XW'(read_index) < XW'(count_q)) && (XW'(read_index) < XW'(DEPTH_C));

  // Next control state for one item
  always_comb begin
    mode_next  = mode_q;
    count_next = count_q;
    tick_next  = tick_q;
    run_next   = run_q;
    ev_go      = 1'b0;
    ev         = EV_LOW;
    take_go    = 1'b0;
    take_mode  = MODE_START;
    we         = 1'b0;

    if (in_xfer) begin
      case (op_c)
        OP_EDGE: begin
          run_next = 1'b0;
          ev_go    = 1'b1;
          ev       = pin_level ? EV_HIGH : EV_LOW;
        end
        OP_TICK: begin
          if (run_q) begin
            if (tick_q >= timeout_limit) begin
              run_next  = 1'b0;
              tick_next = '0;
              ev_go     = 1'b1;
              ev        = EV_TIMEOUT;
            end else begin
              tick_next = tick_q + 1'b1;
            end
          end
        end
        OP_RELEASE: begin
          if (mode_q == MODE_DONE) begin
            mode_next = MODE_START;
          end
        end
        default: ;
      endcase
    end

    // Advance the capture mode on an edge or timeout
    if (ev_go) begin
      case (mode_q)
        MODE_START: begin
          if (ev == EV_LOW) begin
            tick_next  = '0;
            run_next   = 1'b1;
            count_next = '0;
            mode_next  = MODE_HIGH;
          end
        end
        MODE_HIGH: begin
          if (ev == EV_HIGH) begin
            take_go   = 1'b1;
            take_mode = MODE_LOW;
          end else begin
            mode_next = MODE_START;
          end
        end
        MODE_LOW: begin
          if (ev == EV_TIMEOUT) begin
            mode_next = MODE_DONE;
          end else if (ev == EV_LOW) begin
            take_go   = 1'b1;
            take_mode = MODE_HIGH;
          end else begin
            mode_next = MODE_START;
          end
        end
        default: ;
      endcase
    end

    // Store a width, or drop the message when the store is full
    if (take_go) begin
      if (count_q < DEPTH_C) begin
        we         = 1'b1;
        count_next = count_q + 1'b1;
        tick_next  = '0;
        run_next   = 1'b1;
        mode_next  = take_mode;
      end else begin
        mode_next = MODE_START;
      end
    end
  end

  // Hold control state and the timeout limit
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TIMEOUT_RESET;
      mode_q        <= MODE_START;
      count_q       <= '0;
      tick_q        <= '0;
      run_q         <= 1'b0;
      s1_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        timeout_limit <= cfg_data;
      end
      mode_q   <= mode_next;
      count_q  <= count_next;
      tick_q   <= tick_next;
      run_q    <= run_next;
      s1_valid <= in_xfer;
    end
  end

  // Capture the result fields alongside the store read
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_mode  <= mode_next;
      s1_count <= count_next;
      s1_rd    <= (op_c == OP_READ) && rd_ok;
    end
  end

  ipwc_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(count_q)),
    .wdata (tick_q),
    .re    (in_xfer && (op_c == OP_READ)),
    .raddr (AW'(read_index)),
    .rdata (rdata)
  );

  // Assemble the result, zero data unless a valid read
  always_comb begin
    s1_res.mode          = s1_mode;
    s1_res.message_ready = (s1_mode == MODE_DONE);
    s1_res.pulse_count   = CNT_W'(s1_count);
    s1_res.read_data     = s1_rd ? rdata : '0;
  end

  ipwc_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .push_data (s1_res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (q_data),
    .level     (q_level)
  );

  assign mode          = q_data.mode;
  assign message_ready = q_data.message_ready;
  assign pulse_count   = q_data.pulse_count;
  assign read_data     = q_data.read_data;

endmodule

`default_nettype wire

// File: sv/ipwc_checker.sv
// ----------------------------------------------------------------------------
// ipwc_checker
// Port-level checks for the IR pulse-width capture block.
// ----------------------------------------------------------------------------
`default_nettype none

module ipwc_checker #(
  parameter int unsigned DEPTH = ipwc_pkg::DEPTH_DEF
) (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [1:0]                   mode,
  input wire logic                         message_ready,
  input wire logic [ipwc_pkg::CNT_W-1:0]   pulse_count,
  input wire logic [ipwc_pkg::WIDTH_W-1:0] read_data
);
  import ipwc_pkg::*;

  localparam logic [CNT_W:0] DEPTH_C = (CNT_W + 1)'(DEPTH);

  // Drop any output right after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // Flag done exactly in the done mode
  a_ready_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (message_ready == (mode == MODE_DONE)))
    else $error("message_ready disagrees with mode");

  // Count never exceeds the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, pulse_count} <= DEPTH_C))
    else $error("pulse_count beyond depth");

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mode) && $stable(pulse_count)
      && $stable(read_data))
    else $error("stalled result changed");

endmodule

bind ir_pulse_width_capture ipwc_checker #(
  .DEPTH (DEPTH)
) u_ipwc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .mode          (mode),
  .message_ready (message_ready),
  .pulse_count   (pulse_count),
  .read_data     (read_data)
);

`default_nettype wire

// File: sim/ipwc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipwc_checker
// Watches both channels of the IR capture block and checks every status item.
// ----------------------------------------------------------------------------
// Keeps its own copy of the capture state: mode, width count, tick counter,
// timer run flag, width store and timeout limit. Each input transfer updates
// that copy and queues the status it should produce. Each output transfer is
// compared field by field with the oldest queued status. The number of
// failures and the number of statuses still owed go back to the testbench top.
// ----------------------------------------------------------------------------

module ipwc_tb_checker #(
  parameter int unsigned DEPTH = ipwc_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [ipwc_pkg::WIDTH_W-1:0] cfg_data,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [ipwc_pkg::OP_W-1:0]    op,
  input  logic                         pin_level,
  input  logic [ipwc_pkg::IDX_W-1:0]   read_index,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [1:0]                   mode,
  input  logic                         message_ready,
  input  logic [ipwc_pkg::CNT_W-1:0]   pulse_count,
  input  logic [ipwc_pkg::WIDTH_W-1:0] read_data,
  output int unsigned                  mismatch_count,
  output int unsigned                  outstanding
);

  // What the pin or the timer reports to the capture state machine
  typedef enum logic [1:0] {
    EV_HIGH,
    EV_LOW,
    EV_TIMEOUT
  } pin_event_t;

  logic [ipwc_pkg::WIDTH_W-1:0] limit_q;
  ipwc_pkg::mode_t              mode_q;
  int unsigned                  width_total;
  logic [ipwc_pkg::WIDTH_W-1:0] tick_q;
  bit                           timer_on;
  logic [ipwc_pkg::WIDTH_W-1:0] width_mem [DEPTH];
  ipwc_pkg::result_t            status_queue [$];

  initial begin
    mismatch_count = 0;
    outstanding    = 0;
  end

  // Latch the running tick count as a width and restart the timer, or go back to start when the store is full
  function automatic void store_width(ipwc_pkg::mode_t next_mode);
    if (width_total < DEPTH) begin
      width_mem[width_total] = tick_q;
      width_total++;
      tick_q   = '0;
      timer_on = 1'b1;
      mode_q   = next_mode;
    end else begin
      mode_q = ipwc_pkg::MODE_START;
    end
  endfunction

  function automatic void apply_event(pin_event_t ev);
    case (mode_q)
      ipwc_pkg::MODE_START: begin
        if (ev == EV_LOW) begin
          tick_q      = '0;
          timer_on    = 1'b1;
          width_total = 0;
          mode_q      = ipwc_pkg::MODE_HIGH;
        end
      end
      ipwc_pkg::MODE_HIGH: begin
        if (ev == EV_HIGH) store_width(ipwc_pkg::MODE_LOW);
        else mode_q = ipwc_pkg::MODE_START;
      end
      ipwc_pkg::MODE_LOW: begin
        if (ev == EV_TIMEOUT) mode_q = ipwc_pkg::MODE_DONE;
        else if (ev == EV_LOW) store_width(ipwc_pkg::MODE_HIGH);
        else mode_q = ipwc_pkg::MODE_START;
      end
      default: ;
    endcase
  endfunction

  // Advance the capture state by one item and return the status it yields
  function automatic ipwc_pkg::result_t capture_step(ipwc_pkg::op_t code, logic lv,
                                                     logic [ipwc_pkg::IDX_W-1:0] ix);
    ipwc_pkg::result_t r;
    r.read_data = '0;
    case (code)
      ipwc_pkg::OP_EDGE: begin
        timer_on = 1'b0;
        apply_event(lv ? EV_HIGH : EV_LOW);
      end
      ipwc_pkg::OP_TICK: begin
        if (timer_on) begin
          if (tick_q >= limit_q) begin
            timer_on = 1'b0;
            tick_q   = '0;
            apply_event(EV_TIMEOUT);
          end else begin
            tick_q = tick_q + 1'b1;
          end
        end
      end
      ipwc_pkg::OP_READ: begin
        if (ix < width_total && ix < DEPTH) r.read_data = width_mem[ix];
      end
      default: begin
        if (mode_q == ipwc_pkg::MODE_DONE) mode_q = ipwc_pkg::MODE_START;
      end
    endcase
    r.mode          = mode_q;
    r.message_ready = (mode_q == ipwc_pkg::MODE_DONE);
    r.pulse_count   = 8'(width_total);
    return r;
  endfunction

  // Compare outputs first, then take in configuration and new items
  always @(posedge clk) begin
    ipwc_pkg::result_t want;
    if (rst) begin
      limit_q     = ipwc_pkg::TIMEOUT_RESET;
      mode_q      = ipwc_pkg::MODE_START;
      width_total = 0;
      tick_q      = '0;
      timer_on    = 1'b0;
      status_queue.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (status_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected status: mode %0d ready %0b count %0d data %0d",
                     $time, mode, message_ready, pulse_count, read_data);
        end else begin
          want = status_queue.pop_front();
          if (mode !== want.mode || message_ready !== want.message_ready ||
              pulse_count !== want.pulse_count || read_data !== want.read_data) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display(
                "%0t: mode/ready/count/data expected %0d/%0b/%0d/%0d got %0d/%0b/%0d/%0d",
                $time, want.mode, want.message_ready, want.pulse_count, want.read_data,
                mode, message_ready, pulse_count, read_data);
          end
        end
      end
      if (cfg_we) limit_q = cfg_data;
      if (in_valid && in_ready)
        status_queue.push_back(capture_step(ipwc_pkg::op_t'(op), pin_level, read_index));
    end
    outstanding = status_queue.size();
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the IR pulse-width capture block.
// ----------------------------------------------------------------------------
// Drives a short directed sequence over the corner cases of the capture state
// machine, then random IR messages in four flow-control phases: well-formed
// alternating pulses ending in a timeout, read-out and release, mixed with
// broken messages and noise items. The timeout limit changes between messages
// while the block is quiet. The checker beside the block predicts and
// compares every status item.
// ----------------------------------------------------------------------------

module testbench;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         cfg_we;
  logic [ipwc_pkg::WIDTH_W-1:0] cfg_data;
  logic                         in_valid;
  logic                         in_ready;
  logic [ipwc_pkg::OP_W-1:0]    op;
  logic                         pin_level;
  logic [ipwc_pkg::IDX_W-1:0]   read_index;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [1:0]                   mode;
  logic                         message_ready;
  logic [ipwc_pkg::CNT_W-1:0]   pulse_count;
  logic [ipwc_pkg::WIDTH_W-1:0] read_data;

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  int unsigned items_sent = 0;
  int unsigned cur_limit  = ipwc_pkg::TIMEOUT_RESET;

  ir_pulse_width_capture u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .pin_level     (pin_level),
    .read_index    (read_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .mode          (mode),
    .message_ready (message_ready),
    .pulse_count   (pulse_count),
    .read_data     (read_data)
  );

  ipwc_tb_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .pin_level      (pin_level),
    .read_index     (read_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .mode           (mode),
    .message_ready  (message_ready),
    .pulse_count    (pulse_count),
    .read_data      (read_data),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always #5 clk = ~clk;

  // Stall the status side at random
  always @(negedge clk) begin
    out_ready = rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  // Offer one item after a random idle gap and hold it until the transfer.
  // Ready only changes at the rising edge, so its value at the falling edge
  // tells whether the next rising edge takes the item.
  task automatic send_item(ipwc_pkg::op_t code, logic lv, logic [ipwc_pkg::IDX_W-1:0] ix);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    op         = code;
    pin_level  = lv;
    read_index = ix;
    while (!in_ready) @(negedge clk);
    @(negedge clk);
    in_valid = 1'b0;
    items_sent++;
  endtask

  task automatic send_ticks(int unsigned n);
    repeat (n) send_item(ipwc_pkg::OP_TICK, 1'($urandom), 7'($urandom));
  endtask

  task automatic send_noise();
    send_item(ipwc_pkg::op_t'($urandom_range(3)), 1'($urandom), 7'($urandom));
  endtask

  // Wait until the block owes nothing, then load a new timeout limit
  task automatic set_limit(int unsigned lim);
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_data  = 8'(lim);
    cur_limit = lim;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // One IR message: start low, alternating edges, timeout, read-out, release.
  // Unless clean, sprinkle in noise, stray reads, wrong levels, early timeouts and skipped releases.
  task automatic run_message(int unsigned n_edges, int unsigned max_tick, bit clean);
    int unsigned span;
    int unsigned top_idx;
    logic        lv;
    span    = (max_tick < cur_limit) ? max_tick : cur_limit;
    top_idx = (n_edges < 128) ? n_edges : 127;
    if (!clean) repeat ($urandom_range(2)) send_noise();
    send_item(ipwc_pkg::OP_EDGE, 1'b0, 7'($urandom));
    for (int unsigned e = 0; e < n_edges; e++) begin
      if (!clean && $urandom_range(19) == 0) send_ticks(cur_limit + 1);
      else send_ticks($urandom_range(span));
      if (!clean && $urandom_range(9) == 0)
        send_item(ipwc_pkg::OP_READ, 1'($urandom), 7'($urandom_range(e)));
      lv = (e % 2 == 0);
      if (!clean && $urandom_range(24) == 0) lv = ~lv;
      send_item(ipwc_pkg::OP_EDGE, lv, 7'($urandom));
    end
    // let the timer run out while waiting for low
    send_ticks(cur_limit + 1 + $urandom_range(2));
    repeat ($urandom_range(1, 4))
      send_item(ipwc_pkg::OP_READ, 1'($urandom),
                ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(top_idx)));
    if (clean || $urandom_range(9) != 0)
      send_item(ipwc_pkg::OP_RELEASE, 1'($urandom), 7'($urandom));
  endtask

  initial begin
    int unsigned phase_end;
    int unsigned pick;
    int unsigned new_lim;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    op         = ipwc_pkg::OP_EDGE;
    pin_level  = 1'b0;
    read_index = '0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Reads, release, tick and high edge while waiting for start
    send_item(ipwc_pkg::OP_READ, 1'b0, 7'd0);
    send_item(ipwc_pkg::OP_READ, 1'b1, 7'd127);
    send_item(ipwc_pkg::OP_RELEASE, 1'b0, 7'd0);
    send_item(ipwc_pkg::OP_TICK, 1'b0, 7'd0);
    send_item(ipwc_pkg::OP_EDGE, 1'b1, 7'd0);
    // Start, then a wrong level while waiting for high
    send_item(ipwc_pkg::OP_EDGE, 1'b0, 7'd0);
    send_ticks(2);
    send_item(ipwc_pkg::OP_EDGE, 1'b0, 7'd0);
    // Zero width, then a wrong level while waiting for low
    send_item(ipwc_pkg::OP_EDGE, 1'b0, 7'd0);
    send_item(ipwc_pkg::OP_EDGE, 1'b1, 7'd0);
    send_ticks(1);
    send_item(ipwc_pkg::OP_EDGE, 1'b1, 7'd0);
    // Zero limit: timeout while waiting for high, then a done message
    set_limit(0);
    send_item(ipwc_pkg::OP_EDGE, 1'b0, 7'd0);
    send_ticks(1);
    send_item(ipwc_pkg::OP_EDGE, 1'b0, 7'd0);
    send_item(ipwc_pkg::OP_EDGE, 1'b1, 7'd0);
    send_ticks(1);
    // Edge and tick ignored when done, in and out of range reads, double release
    send_item(ipwc_pkg::OP_EDGE, 1'b0, 7'd0);
    send_ticks(1);
    send_item(ipwc_pkg::OP_READ, 1'b0, 7'd0);
    send_item(ipwc_pkg::OP_READ, 1'b0, 7'd1);
    send_item(ipwc_pkg::OP_RELEASE, 1'b0, 7'd0);
    send_item(ipwc_pkg::OP_RELEASE, 1'b0, 7'd0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 88; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      phase_end = items_sent + 220;
      if (ph == 0) begin
        // Widest pulse at the largest limit
        set_limit(255);
        send_item(ipwc_pkg::OP_EDGE, 1'b0, 7'd0);
        send_ticks(255);
        send_item(ipwc_pkg::OP_EDGE, 1'b1, 7'd0);
        send_ticks(256);
        send_item(ipwc_pkg::OP_READ, 1'b0, 7'd0);
        send_item(ipwc_pkg::OP_RELEASE, 1'b0, 7'd0);
        // Fill the store and overflow it by one edge
        set_limit(3);
        run_message(ipwc_pkg::DEPTH_DEF + 1, 2, 1'b1);
      end
      while (items_sent < phase_end) begin
        pick    = $urandom_range(19);
        new_lim = (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(1, 12);
        set_limit(new_lim);
        repeat ((new_lim == 255) ? 1 : 3) begin
          if ($urandom_range(5) == 0) repeat ($urandom_range(1, 6)) send_noise();
          run_message(2 * $urandom_range(7) + 1, $urandom_range(6), 1'b0);
        end
      end
    end

    // Drain, then allow for any stray late status
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("ir_pulse_width_capture verification clean");
    end else begin
      $display("ir_pulse_width_capture verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("ir_pulse_width_capture verification failed");
    $finish;
  end

endmodule
